FILE: hdl/dmn_pkg.sv
// Shared types, constants and the ordering function of the distributed mutex node.
package dmn_pkg;

   localparam int NODES     = 8;
   localparam int TIME_BITS = 32;
   localparam int STORE_CAP = NODES - 1;
   localparam int ID_W      = 3;
   localparam int CNT_W     = $clog2(STORE_CAP + 1);
   localparam int TALLY_W   = 4;
   localparam int TICK_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [ID_W-1:0]    RST_NODE_ID    = '0;
   localparam logic [TALLY_W-1:0] RST_NODE_COUNT = TALLY_W'(8);
   localparam logic [TICK_W-1:0]  RST_CS_TIME    = TICK_W'(2);
   localparam logic [TALLY_W-1:0] TALLY_MAX      = '1;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_LOCAL_REQ = 2'd1,
      CMD_PEER_REQ  = 2'd2,
      CMD_PEER_REP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WANT = 2'd1,
      MODE_CS   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_ID    = 2'd0,
      CSR_NODE_COUNT = 2'd1,
      CSR_CS_TIME    = 2'd2
   } csr_index_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] stamp;
      logic [ID_W-1:0]      node;
   } dmn_entry_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } dmn_ctrl_type;

   // True when pair a orders strictly ahead of pair b by (time, id).
   function automatic logic entry_before(input dmn_entry_type a, input dmn_entry_type b);
      entry_before = (a.stamp < b.stamp) || ((a.stamp == b.stamp) && (a.node < b.node));
   endfunction

endpackage

FILE: hdl/dmn_cell.sv
// One cell of the sorted deferral chain: holds a single deferred request.
module dmn_cell (
   input  logic                  clock,
   input  dmn_pkg::dmn_ctrl_type  ctrl,
   input  dmn_pkg::dmn_entry_type new_entry,
   input  dmn_pkg::dmn_entry_type left_entry,
   input  dmn_pkg::dmn_entry_type right_entry,
   input  logic                  occupied,
   input  logic                  prev_occupied,
   input  logic                  prev_later,
   output dmn_pkg::dmn_entry_type entry,
   output logic                  later
);
   import dmn_pkg::*;

   dmn_entry_type entry_ff;
   dmn_entry_type entry_in;
   logic          take_new;

   // This entry ranks behind the newcomer, so the newcomer goes here or further left.
   assign later    = occupied && entry_before(new_entry, entry_ff);
   assign take_new = !prev_later && (later || (!occupied && prev_occupied));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.drain) begin
         entry_in = right_entry;
      end else if (ctrl.insert) begin
         if (prev_later) begin
            entry_in = left_entry;
         end else if (take_new) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: hdl/dmn_chain.sv
// Row of deferral cells kept sorted by (time, id), drained from the head.
module dmn_chain (
   input  logic                       clock,
   input  dmn_pkg::dmn_ctrl_type       ctrl,
   input  dmn_pkg::dmn_entry_type      new_entry,
   input  logic [dmn_pkg::CNT_W-1:0]  total,
   output dmn_pkg::dmn_entry_type      head
);
   import dmn_pkg::*;

   dmn_entry_type ent   [STORE_CAP];
   logic          later [STORE_CAP];
   logic          occ   [STORE_CAP];

   genvar k;
   generate
      for (k = 0; k < STORE_CAP; k++) begin : g_cell
         dmn_entry_type left_e;
         dmn_entry_type right_e;
         logic          prev_occ;
         logic          prev_lat;

         assign occ[k] = (total > CNT_W'(k));

         if (k == 0) begin : g_first
            assign left_e   = new_entry;
            assign prev_occ = 1'b1;
            assign prev_lat = 1'b0;
         end else begin : g_rest
            assign left_e   = ent[k-1];
            assign prev_occ = occ[k-1];
            assign prev_lat = later[k-1];
         end

         if (k == STORE_CAP - 1) begin : g_tail
            assign right_e = ent[k];
         end else begin : g_mid
            assign right_e = ent[k+1];
         end

         dmn_cell u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .new_entry     (new_entry),
            .left_entry    (left_e),
            .right_entry   (right_e),
            .occupied      (occ[k]),
            .prev_occupied (prev_occ),
            .prev_later    (prev_lat),
            .entry         (ent[k]),
            .later         (later[k])
         );
      end
   endgenerate

   assign head = ent[0];

endmodule

FILE: hdl/distributed_mutex_node.sv
// Top level of one node of a timestamp-ordered distributed mutual exclusion scheme.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | command, now, peer_id, msg_time
//  rsp     | out       | rsp_valid / rsp_ready | has_reply, reply_dest, reply_time,
//          |           |                       | node_mode, last
//  csr     | in        | csr_valid / csr_ready | index, data (always ready)
//
// An input transaction is taken at an edge that also loads its first result into the output
// register; a new input is taken in any non-drain cycle in which that register is empty or
// being read. A tick that ends the critical section with n deferred peers gives n results,
// one per cycle while rsp is ready, from the chain head; no input is taken until the last.
// Reset is synchronous and clears the mode, counters and chain fill count.
// Back-pressure on rsp stalls the node without losing or repeating a result.
module distributed_mutex_node (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [dmn_pkg::TIME_BITS-1:0]     req_now,
   input  logic [dmn_pkg::ID_W-1:0]          req_peer_id,
   input  logic [dmn_pkg::TIME_BITS-1:0]     req_msg_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_has_reply,
   output logic [dmn_pkg::ID_W-1:0]          rsp_reply_dest,
   output logic [dmn_pkg::TIME_BITS-1:0]     rsp_reply_time,
   output logic [1:0]                        rsp_node_mode,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dmn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dmn_pkg::CSR_DAT_W-1:0]     csr_data
);
   import dmn_pkg::*;

   // Configuration registers.
   logic [ID_W-1:0]    node_id_ff;
   logic [TALLY_W-1:0] node_count_ff;
   logic [TICK_W-1:0]  cs_time_ff;

   // Node state.
   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [TIME_BITS-1:0]  stamp_ff, stamp_in;
   logic [TALLY_W-1:0]    tally_ff, tally_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [TIME_BITS-1:0]  drain_time_ff, drain_time_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [ID_W-1:0]       rsp_dest_ff, rsp_dest_in;
   logic [TIME_BITS-1:0]  rsp_time_ff, rsp_time_in;
   mode_type              rsp_mode_ff, rsp_mode_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  accept;
   cmd_type               cmd;
   logic [TALLY_W-1:0]    needed;
   logic [TALLY_W-1:0]    tally_sat;
   logic                  section_end;
   logic                  peer_first;
   dmn_entry_type         peer_entry;
   dmn_entry_type         own_entry;
   dmn_entry_type         head;
   dmn_ctrl_type          ctrl;

   assign cmd        = cmd_type'(req_command);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // A node count of zero or one needs no replies at all.
   assign needed      = (node_count_ff >= TALLY_W'(1)) ? node_count_ff - TALLY_W'(1) : '0;
   assign tally_sat   = (tally_ff == TALLY_MAX) ? tally_ff : tally_ff + TALLY_W'(1);
   // The section ends on the tick that brings the remaining count to zero; a zero
   // section time behaves as one.
   assign section_end = (mode_ff == MODE_CS) && (ticks_ff <= TICK_W'(1));

   assign peer_entry.stamp = req_msg_time;
   assign peer_entry.node  = req_peer_id;
   assign own_entry.stamp  = stamp_ff;
   assign own_entry.node   = node_id_ff;
   assign peer_first       = entry_before(peer_entry, own_entry);

   dmn_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_entry (peer_entry),
      .total     (total_ff),
      .head      (head)
   );

   // Next state: the drain state covers every deferred reply after the first.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (cmd == CMD_TICK) && section_end && (total_ff > CNT_W'(1))) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (out_free && (total_ff == CNT_W'(1))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and result register loading.
   always_comb begin
      mode_in       = mode_ff;
      stamp_in      = stamp_ff;
      tally_in      = tally_ff;
      ticks_in      = ticks_ff;
      total_in      = total_ff;
      drain_time_in = drain_time_ff;
      ctrl          = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_has_in    = rsp_has_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_has_in   = 1'b1;
               rsp_dest_in  = head.node;
               rsp_time_in  = drain_time_ff;
               rsp_mode_in  = mode_ff;
               rsp_last_in  = (total_ff == CNT_W'(1));
               ctrl.drain   = 1'b1;
               total_in     = total_ff - CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_has_in   = 1'b0;
               rsp_dest_in  = '0;
               rsp_time_in  = '0;
               rsp_last_in  = 1'b1;
               case (cmd)
                  CMD_TICK: begin
                     if (mode_ff == MODE_CS) begin
                        if (ticks_ff != '0) begin
                           ticks_in = ticks_ff - TICK_W'(1);
                        end
                        if (section_end) begin
                           mode_in  = MODE_IDLE;
                           tally_in = '0;
                           if (total_ff != '0) begin
                              // The first deferred reply leaves with this transaction.
                              rsp_has_in    = 1'b1;
                              rsp_dest_in   = head.node;
                              rsp_time_in   = req_now;
                              rsp_last_in   = (total_ff == CNT_W'(1));
                              ctrl.drain    = 1'b1;
                              total_in      = total_ff - CNT_W'(1);
                              drain_time_in = req_now;
                           end
                        end
                     end
                  end
                  CMD_LOCAL_REQ: begin
                     if (mode_ff == MODE_IDLE) begin
                        stamp_in = req_now;
                        tally_in = '0;
                        if (needed == '0) begin
                           mode_in  = MODE_CS;
                           ticks_in = cs_time_ff;
                        end else begin
                           mode_in  = MODE_WANT;
                        end
                     end
                  end
                  CMD_PEER_REQ: begin
                     if ((mode_ff == MODE_IDLE) || ((mode_ff == MODE_WANT) && peer_first)) begin
                        rsp_has_in  = 1'b1;
                        rsp_dest_in = req_peer_id;
                        rsp_time_in = req_now;
                     end else if (total_ff < CNT_W'(STORE_CAP)) begin
                        // Deferred; a request that finds the chain full is dropped.
                        ctrl.insert = 1'b1;
                        total_in    = total_ff + CNT_W'(1);
                     end
                  end
                  CMD_PEER_REP: begin
                     if (mode_ff == MODE_WANT) begin
                        if (tally_sat == needed) begin
                           mode_in  = MODE_CS;
                           tally_in = '0;
                           ticks_in = cs_time_ff;
                        end else begin
                           tally_in = tally_sat;
                        end
                     end
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
               rsp_mode_in = mode_in;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_IDLE;
         stamp_ff      <= '0;
         tally_ff      <= '0;
         ticks_ff      <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         node_id_ff    <= RST_NODE_ID;
         node_count_ff <= RST_NODE_COUNT;
         cs_time_ff    <= RST_CS_TIME;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         stamp_ff     <= stamp_in;
         tally_ff     <= tally_in;
         ticks_ff     <= ticks_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_NODE_ID:    node_id_ff    <= csr_data[ID_W-1:0];
               CSR_NODE_COUNT: node_count_ff <= csr_data[TALLY_W-1:0];
               CSR_CS_TIME:    cs_time_ff    <= csr_data[TICK_W-1:0];
               default:        node_id_ff    <= node_id_ff;
            endcase
         end
      end
   end

   // Result payload and drain stamp carry no reset.
   always_ff @(posedge clock) begin
      drain_time_ff <= drain_time_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_reply  = rsp_has_ff;
   assign rsp_reply_dest = rsp_dest_ff;
   assign rsp_reply_time = rsp_time_ff;
   assign rsp_node_mode  = rsp_mode_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> !req_ready)
      else $error("input taken while deferred replies are draining");

   a_total_in_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(STORE_CAP))
      else $error("deferral chain fill count beyond capacity");

   a_drain_idle_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> ((mode_ff == MODE_IDLE) && (total_ff != '0)))
      else $error("draining outside idle mode or with an empty chain");

   a_not_last_needs_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_has_ff && (state_ff == S_DRAIN)))
      else $error("non-final result without a pending drain");

   a_section_clears_tally: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CS) |-> (tally_ff == '0))
      else $error("reply tally left set inside the critical section");
`endif

endmodule

FILE: sim/distributed_mutex_node_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the distributed mutex node, with its own model of the node.
module distributed_mutex_node_test;
   import dmn_pkg::*;

   // Cycle limit on the whole run, set with a wide margin.
   localparam int CYCLE_LIMIT = 200000;
   // Chance, in percent, that either side idles in a given cycle.
   localparam int IDLE_PCT    = 29;
   // Length of the long receiver hold-off used to fill the node and stall its input.
   localparam int HOLD_CYCLES = 150;
   // Cycles allowed for the node to settle once every expected result has arrived.
   localparam int SETTLE      = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_command = CMD_TICK;
   logic [TIME_BITS-1:0] req_now = '0;
   logic [ID_W-1:0]      req_peer_id = '0;
   logic [TIME_BITS-1:0] req_msg_time = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_has_reply;
   logic [ID_W-1:0]      rsp_reply_dest;
   logic [TIME_BITS-1:0] rsp_reply_time;
   logic [1:0]           rsp_node_mode;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NODE_ID;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   distributed_mutex_node uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_now       (req_now),
      .req_peer_id   (req_peer_id),
      .req_msg_time  (req_msg_time),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_has_reply (rsp_has_reply),
      .rsp_reply_dest(rsp_reply_dest),
      .rsp_reply_time(rsp_reply_time),
      .rsp_node_mode (rsp_node_mode),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One result record as the node should present it.
   typedef struct packed {
      logic                 has_reply;
      logic [ID_W-1:0]      dest;
      logic [TIME_BITS-1:0] stamp;
      mode_type             mode;
      logic                 last;
   } outcome_type;

   outcome_type pending_outcomes[$];
   outcome_type oldest_outcome;

   // Our own copy of the node's configuration.
   logic [ID_W-1:0]    cfg_id;
   logic [TALLY_W-1:0] cfg_count;
   logic [TICK_W-1:0]  cfg_cs;

   // Our own copy of the node's state, including the sorted store of deferred requests.
   mode_type             node_mode;
   logic [TIME_BITS-1:0] own_stamp;
   logic [TALLY_W-1:0]   reply_count;
   logic [TICK_W-1:0]    ticks_to_go;
   logic [TIME_BITS-1:0] held_stamp[STORE_CAP];
   logic [ID_W-1:0]      held_node[STORE_CAP];
   int                   held_total;

   int                   mismatches = 0;
   int                   cycle_count = 0;
   int                   hold_left = 0;
   logic                 steady = 1'b0;
   logic [TIME_BITS-1:0] wall_clock = 32'd1000;

   // True when the pair (ta, ia) orders strictly ahead of (tb, ib).
   function automatic bit pair_ahead(input logic [TIME_BITS-1:0] ta, input logic [ID_W-1:0] ia,
                                     input logic [TIME_BITS-1:0] tb, input logic [ID_W-1:0] ib);
      return (ta < tb) || ((ta == tb) && (ia < ib));
   endfunction

   task automatic enter_section();
      node_mode   = MODE_CS;
      reply_count = '0;
      ticks_to_go = cfg_cs;
   endtask

   // Sorted insertion behind any equal pairs, so that equal entries keep their arrival order.
   // A request that finds the store full is lost.
   task automatic hold_request(input logic [TIME_BITS-1:0] t, input logic [ID_W-1:0] id);
      int pos;
      if (held_total >= STORE_CAP) return;
      pos = held_total;
      for (int k = 0; k < held_total; k++) begin
         if (pair_ahead(t, id, held_stamp[k], held_node[k])) begin
            pos = k;
            break;
         end
      end
      for (int k = held_total; k > pos; k--) begin
         held_stamp[k] = held_stamp[k-1];
         held_node[k]  = held_node[k-1];
      end
      held_stamp[pos] = t;
      held_node[pos]  = id;
      held_total++;
   endtask

   // Advances our model by one accepted transaction and queues the results it must cause.
   task automatic predict_outcomes(input cmd_type cmd, input logic [TIME_BITS-1:0] now,
                                   input logic [ID_W-1:0] peer,
                                   input logic [TIME_BITS-1:0] mt);
      logic [ID_W-1:0] dests[$];
      int              needed;
      outcome_type     o;
      needed = (cfg_count >= 1) ? int'(cfg_count) - 1 : 0;
      case (cmd)
         CMD_TICK: begin
            // A tick only matters inside the section; a spent count releases every waiter.
            if (node_mode == MODE_CS) begin
               if (ticks_to_go > 0) ticks_to_go--;
               if (ticks_to_go == 0) begin
                  node_mode   = MODE_IDLE;
                  reply_count = '0;
                  for (int i = 0; i < held_total; i++) dests.insert(dests.size(), held_node[i]);
                  held_total = 0;
               end
            end
         end
         CMD_LOCAL_REQ: begin
            if (node_mode == MODE_IDLE) begin
               node_mode   = MODE_WANT;
               own_stamp   = now;
               reply_count = '0;
               if (needed == 0) enter_section();
            end
         end
         CMD_PEER_REQ: begin
            if (node_mode == MODE_IDLE) begin
               dests.insert(dests.size(), peer);
            end else if (node_mode == MODE_WANT && pair_ahead(mt, peer, own_stamp, cfg_id)) begin
               dests.insert(dests.size(), peer);
            end else begin
               hold_request(mt, peer);
            end
         end
         default: begin
            // Replies that arrive while not wanting are stray and change nothing.
            if (node_mode == MODE_WANT) begin
               if (reply_count != TALLY_MAX) reply_count++;
               if (int'(reply_count) == needed) enter_section();
            end
         end
      endcase
      if (dests.size() == 0) begin
         o = '{has_reply: 1'b0, dest: '0, stamp: '0, mode: node_mode, last: 1'b1};
         pending_outcomes.insert(pending_outcomes.size(), o);
      end else begin
         foreach (dests[i]) begin
            o = '{has_reply: 1'b1, dest: dests[i], stamp: now, mode: node_mode,
                  last: (i == dests.size() - 1)};
            pending_outcomes.insert(pending_outcomes.size(), o);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [TIME_BITS-1:0] got,
                                  input logic [TIME_BITS-1:0] wanted);
      $display("cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, wanted);
      mismatches++;
   endtask

   // Offers one transaction from a falling edge and returns at the falling edge after it is
   // taken, with valid still high so that a following transaction can go straight on.
   task automatic send_item(input cmd_type cmd, input logic [TIME_BITS-1:0] now,
                            input logic [ID_W-1:0] peer, input logic [TIME_BITS-1:0] mt);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_command  = cmd;
      req_now      = now;
      req_peer_id  = peer;
      req_msg_time = mt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_outcomes(cmd, now, peer, mt);
      @(negedge clock);
   endtask

   // Drops the request channel and waits until the node has delivered everything owed.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NODE_ID:    cfg_id    = value[ID_W-1:0];
         CSR_NODE_COUNT: cfg_count = value[TALLY_W-1:0];
         default:        cfg_cs    = value;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input logic [ID_W-1:0] id, input logic [TALLY_W-1:0] count,
                            input logic [TICK_W-1:0] cs);
      wait_idle();
      write_reg(CSR_NODE_ID, CSR_DAT_W'(id));
      write_reg(CSR_NODE_COUNT, CSR_DAT_W'(count));
      write_reg(CSR_CS_TIME, cs);
   endtask

   // Random traffic steered by the model's mode, so that most transactions form proper
   // rounds of request, replies and section, with a share of noise mixed in.
   // tick_pct is the chance of a tick while in the section.
   task automatic run_traffic(input int count, input int tick_pct);
      cmd_type              cmd;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] mt;
      logic [ID_W-1:0]      peer;
      int                   roll;
      int                   pick;
      for (int n = 0; n < count; n++) begin
         roll       = $urandom_range(99);
         wall_clock = wall_clock + $urandom_range(3);
         now        = ($urandom_range(9) == 0) ? $urandom : wall_clock;
         peer       = ID_W'($urandom_range(7));
         pick       = $urandom_range(9);
         // Peer stamps cluster round our own so that both orderings and ties are common.
         if (pick < 4)      mt = own_stamp + $urandom_range(4) - 2;
         else if (pick < 6) mt = own_stamp;
         else if (pick < 8) mt = $urandom;
         else               mt = wall_clock;
         if (roll < 12) begin
            cmd = cmd_type'($urandom_range(3));
         end else begin
            case (node_mode)
               MODE_IDLE: begin
                  if (roll < 60)      cmd = CMD_LOCAL_REQ;
                  else if (roll < 88) cmd = CMD_PEER_REQ;
                  else                cmd = CMD_TICK;
               end
               MODE_WANT: begin
                  if (roll < 55)      cmd = CMD_PEER_REP;
                  else if (roll < 88) cmd = CMD_PEER_REQ;
                  else                cmd = CMD_LOCAL_REQ;
               end
               default: begin
                  cmd = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_PEER_REQ;
               end
            endcase
         end
         send_item(cmd, now, peer, mt);
      end
   endtask

   // Idle answers, stray replies and ticks outside the section.
   task automatic check_idle_behaviour();
      configure(3'd3, 4'd3, 8'd1);
      send_item(CMD_TICK, 32'h0, 3'd0, 32'h0);
      send_item(CMD_PEER_REP, 32'h1, 3'd4, 32'h0);
      send_item(CMD_PEER_REQ, 32'hFFFF_FFFF, 3'd7, 32'h0);
      send_item(CMD_PEER_REQ, 32'h5, 3'd0, 32'hFFFF_FFFF);
   endtask

   // Priority decisions, equal pairs, a full store with a dropped request and the reply
   // burst of seven at section end.
   task automatic check_deferral_and_release();
      send_item(CMD_LOCAL_REQ, 32'd100, 3'd0, 32'd0);
      send_item(CMD_LOCAL_REQ, 32'd101, 3'd0, 32'd0);
      send_item(CMD_PEER_REQ, 32'd102, 3'd1, 32'd50);
      send_item(CMD_PEER_REQ, 32'd103, 3'd2, 32'd100);
      send_item(CMD_PEER_REQ, 32'd104, 3'd3, 32'd100);
      send_item(CMD_PEER_REQ, 32'd105, 3'd5, 32'd100);
      send_item(CMD_PEER_REQ, 32'd106, 3'd2, 32'd200);
      send_item(CMD_PEER_REP, 32'd107, 3'd1, 32'd0);
      send_item(CMD_TICK, 32'd108, 3'd0, 32'd0);
      send_item(CMD_PEER_REP, 32'd109, 3'd2, 32'd0);
      send_item(CMD_PEER_REQ, 32'd110, 3'd4, 32'd0);
      send_item(CMD_PEER_REQ, 32'd111, 3'd5, 32'd100);
      send_item(CMD_PEER_REQ, 32'd112, 3'd7, 32'hFFFF_FFFF);
      send_item(CMD_PEER_REQ, 32'd113, 3'd6, 32'd100);
      send_item(CMD_PEER_REQ, 32'd114, 3'd1, 32'd1);
      send_item(CMD_PEER_REP, 32'd115, 3'd2, 32'd0);
      send_item(CMD_LOCAL_REQ, 32'd116, 3'd0, 32'd0);
      send_item(CMD_TICK, 32'hFFFF_FFFF, 3'd0, 32'd0);
   endtask

   // With one node, or a count of zero, no replies are needed; a zero section time acts as one.
   task automatic check_single_node();
      configure(3'd0, 4'd1, 8'd0);
      send_item(CMD_LOCAL_REQ, 32'd200, 3'd0, 32'd0);
      send_item(CMD_TICK, 32'd201, 3'd0, 32'd0);
      configure(3'd7, 4'd0, 8'd1);
      send_item(CMD_LOCAL_REQ, 32'd202, 3'd0, 32'd0);
      send_item(CMD_TICK, 32'd203, 3'd0, 32'd0);
   endtask

   task automatic check_random_rounds();
      configure(ID_W'($urandom_range(7)), 4'd3, 8'd2);
      run_traffic(25, 50);
      configure(3'd7, 4'd8, 8'd1);
      steady <= 1'b1;
      run_traffic(30, 50);
      steady <= 1'b0;
      configure(3'd0, 4'd0, 8'd0);
      run_traffic(10, 50);
      configure(3'd5, 4'd15, 8'd3);
      run_traffic(15, 50);
   endtask

   // The receiver stops for a long stretch while transactions keep coming, so the node fills
   // up and has to refuse further input.
   task automatic check_back_pressure();
      configure(ID_W'($urandom_range(7)), 4'd2, 8'd4);
      req_valid = 1'b0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      run_traffic(35, 50);
   endtask

   // One long stay in the section at the largest section time.
   task automatic check_long_section();
      configure(3'd6, 4'd2, 8'd255);
      run_traffic(290, 92);
   endtask

   // Receiver side: ready changes on the falling edge only.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Every delivered result is compared with the oldest one still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result, mode", TIME_BITS'(rsp_node_mode), '0);
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_has_reply !== oldest_outcome.has_reply)
               report_mismatch("has_reply", TIME_BITS'(rsp_has_reply),
                               TIME_BITS'(oldest_outcome.has_reply));
            if (rsp_reply_dest !== oldest_outcome.dest)
               report_mismatch("reply_dest", TIME_BITS'(rsp_reply_dest),
                               TIME_BITS'(oldest_outcome.dest));
            if (rsp_reply_time !== oldest_outcome.stamp)
               report_mismatch("reply_time", rsp_reply_time, oldest_outcome.stamp);
            if (rsp_node_mode !== oldest_outcome.mode)
               report_mismatch("node_mode", TIME_BITS'(rsp_node_mode),
                               TIME_BITS'(oldest_outcome.mode));
            if (rsp_last !== oldest_outcome.last)
               report_mismatch("last", TIME_BITS'(rsp_last), TIME_BITS'(oldest_outcome.last));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      cfg_id      = RST_NODE_ID;
      cfg_count   = RST_NODE_COUNT;
      cfg_cs      = RST_CS_TIME;
      node_mode   = MODE_IDLE;
      own_stamp   = '0;
      reply_count = '0;
      ticks_to_go = '0;
      held_total  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_idle_behaviour();
      check_deferral_and_release();
      check_single_node();
      check_random_rounds();
      check_back_pressure();
      check_long_section();

      // Everything has been taken; wait for the last results and a little settling time.
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
